>>> rtl/fbft_pkg.sv
`default_nettype none

package fbft_pkg;

  // Action codes carried on the command port
  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_PULL = 2'd1,
    ACT_NEW  = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  // Error codes reported with each add result
  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_DUP   = 3'd1,
    ERR_COUNT = 3'd2,
    ERR_SIZE  = 3'd3,
    ERR_RANGE = 3'd4
  } err_e;

  // A pull releases at most this many indices per transaction
  localparam logic [6:0] RESULT_LIMIT = 7'd64;
  // Fragment counters saturate here
  localparam logic [6:0] CNT_MAX = 7'd127;

  // Block status shown with every result
  typedef struct packed {
    logic              count_known;
    logic              all_available;
    logic              can_recover;
    logic              all_forwarded;
    logic signed [7:0] missing;
    logic [6:0]        forwarded;
  } status_t;

  function automatic status_t fbft_status(input logic       known,
                                          input logic [6:0] total,
                                          input logic [6:0] prim,
                                          input logic [6:0] sec,
                                          input logic [6:0] fwd);
    status_t    st;
    logic [7:0] have;
    have             = {1'b0, prim} + {1'b0, sec};
    st.count_known   = known;
    st.all_available = known && (prim == total);
    st.can_recover   = known && (have >= {1'b0, total});
    st.all_forwarded = known && (fwd == total);
    st.missing       = known ? signed'({1'b0, total} - have) : 8'sd0;
    st.forwarded     = fwd;
    return st;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fbft_map.sv
`default_nettype none

// Fragment availability map: synchronous memory with one read and one write
// port and a registered read, plus per-entry valid bits so reset and new block
// clear it without a pass over the memory.
module fbft_map #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  output logic               hit_o
);

  logic             mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic             rd_mem_q;
  logic             rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= 1'b1;
    end
    if (rd_en_i) begin
      rd_mem_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits and their registered read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign hit_o = rd_vld_q & rd_mem_q;

endmodule

`default_nettype wire

>>> rtl/fec_block_fragment_tracker.sv
`default_nettype none

// Receive bookkeeping for one FEC block.
// Commands enter on start/busy: a transaction is taken at a clock edge with
// start high and busy low. action_i selects add fragment, pull, new block or
// no-op. Results leave on the *_o result ports, each valid for exactly one
// cycle while done_o is high; the receiver cannot stall them.
// Per command:
//   new block / no-op: result in the cycle after accept, busy never rises.
//   add: one map read, then the result is registered; busy is high in S_ADD.
//   pull: two passes over the availability map, one map read per cycle.
//     The first pass counts releasable indices, the second replays them and
//     sends one result per released index. A pull with nothing to walk
//     answers in the next cycle.
// Every result of one command shows the status after the whole command.
// Reset (rst_ni low) and the new block command clear the map and all
// counters at once; no clearing pass is needed.
module fec_block_fragment_tracker #(
  parameter int unsigned MAX_FRAGMENTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action_i,
  input  wire logic [5:0]  fragment_index_i,
  input  wire logic [6:0]  primary_count_i,
  input  wire logic [11:0] payload_len_i,
  input  wire logic        discard_missing_i,
  output logic             done_o,
  output logic [5:0]       out_index_o,
  output logic             index_valid_o,
  output logic             last_result_o,
  output logic [2:0]       error_code_o,
  output logic             count_known_o,
  output logic             all_available_o,
  output logic             can_recover_o,
  output logic             all_forwarded_o,
  output logic signed [7:0] missing_primary_o,
  output logic [6:0]       forwarded_count_o
);

  import fbft_pkg::*;

  localparam int unsigned AW    = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam logic [8:0]  MAX_W = 9'(MAX_FRAGMENTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_COUNT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Latched command
  logic [5:0]  idx_q, idx_d;
  logic [6:0]  pcount_q, pcount_d;
  logic [11:0] plen_q, plen_d;
  logic        skip_q, skip_d;

  // Block state
  logic        known_q, known_d;
  logic [6:0]  total_q, total_d;
  logic [6:0]  prim_q, prim_d;
  logic [6:0]  sec_q, sec_d;
  logic [6:0]  fwd_q, fwd_d;
  logic [11:0] ssize_q, ssize_d;
  logic        sknown_q, sknown_d;

  // Walk control
  logic [6:0]  walk_q, walk_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [6:0]  num_q, num_d;

  // Result registers
  logic        done_q, done_d;
  logic [5:0]  oidx_q, oidx_d;
  logic        ovld_q, ovld_d;
  logic        olast_q, olast_d;
  err_e        err_q, err_d;
  status_t     stat_q, stat_d;

  // Map port
  logic          map_clear;
  logic          map_rd_en;
  logic [AW-1:0] map_rd_addr;
  logic          map_wr_en;
  logic [AW-1:0] map_wr_addr;
  logic          map_hit;

  fbft_map #(
    .DEPTH(MAX_FRAGMENTS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (map_clear),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (map_rd_addr),
    .wr_en_i   (map_wr_en),
    .wr_addr_i (map_wr_addr),
    .hit_o     (map_hit)
  );

  // Walk bounds: index below the primary-available count and the map size
  logic [6:0] walk_inc;
  logic       fwd_in_range;
  logic       inc_in_range;
  logic [6:0] cnt_nx;
  logic       range_bad;
  logic       is_primary;

  assign walk_inc     = walk_q + 7'd1;
  assign fwd_in_range = ({2'b0, fwd_q} < MAX_W) && (fwd_q < prim_q);
  assign inc_in_range = ({2'b0, walk_inc} < MAX_W) && (walk_inc < prim_q);
  assign cnt_nx       = cnt_q + {6'b0, map_hit};
  assign range_bad    = ({3'b0, idx_q} >= MAX_W) || (pcount_q == 7'd0) ||
                        ({2'b0, pcount_q} > MAX_W);
  assign is_primary   = {1'b0, idx_q} < pcount_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pcount_d    = pcount_q;
    plen_d      = plen_q;
    skip_d      = skip_q;
    known_d     = known_q;
    total_d     = total_q;
    prim_d      = prim_q;
    sec_d       = sec_q;
    fwd_d       = fwd_q;
    ssize_d     = ssize_q;
    sknown_d    = sknown_q;
    walk_d      = walk_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    done_d      = 1'b0;
    oidx_d      = 6'd0;
    ovld_d      = 1'b0;
    olast_d     = 1'b0;
    err_d       = ERR_OK;
    map_clear   = 1'b0;
    map_rd_en   = 1'b0;
    map_rd_addr = '0;
    map_wr_en   = 1'b0;
    map_wr_addr = AW'(idx_q);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (action_e'(action_i))
            ACT_ADD: begin
              idx_d       = fragment_index_i;
              pcount_d    = primary_count_i;
              plen_d      = payload_len_i;
              map_rd_en   = 1'b1;
              map_rd_addr = AW'(fragment_index_i);
              state_d     = S_ADD;
            end
            ACT_PULL: begin
              skip_d = discard_missing_i;
              walk_d = fwd_q;
              cnt_d  = 7'd0;
              if (fwd_in_range) begin
                map_rd_en   = 1'b1;
                map_rd_addr = AW'(fwd_q);
                state_d     = S_COUNT;
              end else begin
                done_d  = 1'b1;
                olast_d = 1'b1;
              end
            end
            ACT_NEW: begin
              known_d   = 1'b0;
              total_d   = 7'd0;
              prim_d    = 7'd0;
              sec_d     = 7'd0;
              fwd_d     = 7'd0;
              ssize_d   = 12'd0;
              sknown_d  = 1'b0;
              map_clear = 1'b1;
              done_d    = 1'b1;
              olast_d   = 1'b1;
            end
            default: begin
              done_d  = 1'b1;
              olast_d = 1'b1;
            end
          endcase
        end
      end

      // Map bit for the fragment is back: check in order, then update
      S_ADD: begin
        done_d  = 1'b1;
        olast_d = 1'b1;
        state_d = S_IDLE;
        if (range_bad) begin
          err_d = ERR_RANGE;
        end else if (map_hit) begin
          err_d = ERR_DUP;
        end else if (known_q && (pcount_q != total_q)) begin
          err_d = ERR_COUNT;
        end else if (!is_primary && sknown_q && (plen_q != ssize_q)) begin
          err_d = ERR_SIZE;
        end else begin
          map_wr_en = 1'b1;
          if (!known_q) begin
            known_d = 1'b1;
            total_d = pcount_q;
          end
          if (is_primary) begin
            if (prim_q < CNT_MAX) begin
              prim_d = prim_q + 7'd1;
            end
          end else begin
            if (sec_q < CNT_MAX) begin
              sec_d = sec_q + 7'd1;
            end
            if (!sknown_q) begin
              sknown_d = 1'b1;
              ssize_d  = plen_q;
            end
          end
        end
      end

      // First pass: count what the pull releases
      S_COUNT: begin
        if ((!map_hit && !skip_q) || (cnt_nx == RESULT_LIMIT) || !inc_in_range) begin
          if (cnt_nx == 7'd0) begin
            done_d  = 1'b1;
            olast_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            fwd_d       = fwd_q + cnt_nx;
            num_d       = cnt_nx;
            cnt_d       = 7'd0;
            walk_d      = fwd_q;
            map_rd_en   = 1'b1;
            map_rd_addr = AW'(fwd_q);
            state_d     = S_EMIT;
          end
        end else begin
          cnt_d       = cnt_nx;
          walk_d      = walk_inc;
          map_rd_en   = 1'b1;
          map_rd_addr = AW'(walk_inc);
        end
      end

      // Second pass: replay the walk, one result per available index
      S_EMIT: begin
        if (map_hit) begin
          done_d  = 1'b1;
          ovld_d  = 1'b1;
          oidx_d  = walk_q[5:0];
          olast_d = (cnt_nx == num_q);
          cnt_d   = cnt_nx;
        end
        if (map_hit && (cnt_nx == num_q)) begin
          state_d = S_IDLE;
        end else begin
          walk_d      = walk_inc;
          map_rd_en   = 1'b1;
          map_rd_addr = AW'(walk_inc);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    stat_d = done_d ? fbft_status(known_d, total_d, prim_d, sec_d, fwd_d) : stat_q;
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= 6'd0;
      pcount_q <= 7'd0;
      plen_q   <= 12'd0;
      skip_q   <= 1'b0;
      known_q  <= 1'b0;
      total_q  <= 7'd0;
      prim_q   <= 7'd0;
      sec_q    <= 7'd0;
      fwd_q    <= 7'd0;
      ssize_q  <= 12'd0;
      sknown_q <= 1'b0;
      walk_q   <= 7'd0;
      cnt_q    <= 7'd0;
      num_q    <= 7'd0;
      done_q   <= 1'b0;
      oidx_q   <= 6'd0;
      ovld_q   <= 1'b0;
      olast_q  <= 1'b0;
      err_q    <= ERR_OK;
      stat_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pcount_q <= pcount_d;
      plen_q   <= plen_d;
      skip_q   <= skip_d;
      known_q  <= known_d;
      total_q  <= total_d;
      prim_q   <= prim_d;
      sec_q    <= sec_d;
      fwd_q    <= fwd_d;
      ssize_q  <= ssize_d;
      sknown_q <= sknown_d;
      walk_q   <= walk_d;
      cnt_q    <= cnt_d;
      num_q    <= num_d;
      done_q   <= done_d;
      oidx_q   <= oidx_d;
      ovld_q   <= ovld_d;
      olast_q  <= olast_d;
      err_q    <= err_d;
      stat_q   <= stat_d;
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign out_index_o       = oidx_q;
  assign index_valid_o     = ovld_q;
  assign last_result_o     = olast_q;
  assign error_code_o      = err_q;
  assign count_known_o     = stat_q.count_known;
  assign all_available_o   = stat_q.all_available;
  assign can_recover_o     = stat_q.can_recover;
  assign all_forwarded_o   = stat_q.all_forwarded;
  assign missing_primary_o = stat_q.missing;
  assign forwarded_count_o = stat_q.forwarded;

  // Released indices come only from a pull and never carry an error
  a_idx_no_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_valid_o |-> (done_o && (error_code_o == ERR_OK)))
    else $error("released index with error or without strobe");

  // Replay pass only runs with a nonzero count and stays below it
  a_emit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((num_q != 7'd0) && (cnt_q < num_q)))
    else $error("replay pass out of step with first pass");

  // New block answers at once with the count forgotten
  a_new_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_NEW)) |=>
      (done_o && last_result_o && !count_known_o && (forwarded_count_o == 7'd0)))
    else $error("new block did not clear status");

  // Forwarded-all and all-available status require a latched count
  a_fwd_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (all_forwarded_o || all_available_o)) |-> count_known_o)
    else $error("status flag set while count unknown");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fbft_pkg::*;

  localparam int unsigned MAX_FRAG     = 64;
  localparam int unsigned RANDOM_CMDS  = 350;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 200;

  // Command fields of one transaction
  typedef struct packed {
    action_e     act;
    logic [5:0]  idx;
    logic [6:0]  pcount;
    logic [11:0] len;
    logic        skip;
  } frag_cmd_t;

  // Directed row: command plus an optional hand-typed error code
  typedef struct packed {
    frag_cmd_t cmd;
    bit        typed;
    err_e      terr;
  } dir_row_t;

  // One result as seen on the result ports
  typedef struct packed {
    logic [5:0]        index;
    logic              valid;
    logic              last;
    logic [2:0]        err;
    logic              known;
    logic              all_avail;
    logic              can_rec;
    logic              all_fwd;
    logic signed [7:0] missing;
    logic [6:0]        fwd;
  } frag_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  wire               busy;
  logic [1:0]        action_i;
  logic [5:0]        fragment_index_i;
  logic [6:0]        primary_count_i;
  logic [11:0]       payload_len_i;
  logic              discard_missing_i;
  wire               done_o;
  wire [5:0]         out_index_o;
  wire               index_valid_o;
  wire               last_result_o;
  wire [2:0]         error_code_o;
  wire               count_known_o;
  wire               all_available_o;
  wire               can_recover_o;
  wire               all_forwarded_o;
  wire signed [7:0]  missing_primary_o;
  wire [6:0]         forwarded_count_o;

  fec_block_fragment_tracker DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .fragment_index_i  (fragment_index_i),
    .primary_count_i   (primary_count_i),
    .payload_len_i     (payload_len_i),
    .discard_missing_i (discard_missing_i),
    .done_o            (done_o),
    .out_index_o       (out_index_o),
    .index_valid_o     (index_valid_o),
    .last_result_o     (last_result_o),
    .error_code_o      (error_code_o),
    .count_known_o     (count_known_o),
    .all_available_o   (all_available_o),
    .can_recover_o     (can_recover_o),
    .all_forwarded_o   (all_forwarded_o),
    .missing_primary_o (missing_primary_o),
    .forwarded_count_o (forwarded_count_o)
  );

  // Tracker mirror state
  bit          avail_map [MAX_FRAG];
  logic [6:0]  prim_total;
  logic        total_known;
  logic [6:0]  prim_avail;
  logic [6:0]  sec_avail;
  logic [6:0]  fwd_count;
  logic [11:0] sec_size;
  logic        size_known;

  frag_result_t tracker_results_q [$];
  dir_row_t     dir_rows [$];
  int unsigned  cmds_sent;
  int unsigned  mismatches;
  int unsigned  cycle_cnt;
  int unsigned  idle_pct;
  int unsigned  idle_phase_pct [4] = '{0, 58, 0, 24};

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  function automatic string fmt_result(input frag_result_t r);
    return $sformatf("idx=%0d v=%0d l=%0d e=%0d ck=%0d aa=%0d cr=%0d af=%0d miss=%0d fwd=%0d",
                     r.index, r.valid, r.last, r.err, r.known, r.all_avail,
                     r.can_rec, r.all_fwd, r.missing, r.fwd);
  endfunction

  task automatic clear_block_state();
    foreach (avail_map[i]) avail_map[i] = 1'b0;
    prim_total  = '0;
    total_known = 1'b0;
    prim_avail  = '0;
    sec_avail   = '0;
    fwd_count   = '0;
    sec_size    = '0;
    size_known  = 1'b0;
  endtask

  // Queue one expected result behind the ones already waiting
  task automatic queue_expected(input frag_result_t r);
    tracker_results_q.insert(tracker_results_q.size(), r);
  endtask

  // Append one row to the directed table
  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Apply one accepted command to the mirror and queue its results
  task automatic apply_tracker_cmd(input frag_cmd_t c, input bit typed, input err_e terr);
    logic [5:0]   released [$];
    err_e         e;
    frag_result_t r;
    logic [7:0]   have;
    bit           is_prim;
    int unsigned  i;
    e = ERR_OK;
    case (c.act)
      ACT_ADD: begin
        is_prim = ({1'b0, c.idx} < c.pcount);
        if (c.pcount == 7'd0 || c.pcount > 7'(MAX_FRAG)) e = ERR_RANGE;
        else if (avail_map[c.idx]) e = ERR_DUP;
        else if (total_known && c.pcount != prim_total) e = ERR_COUNT;
        else if (!is_prim && size_known && c.len != sec_size) e = ERR_SIZE;
        else begin
          avail_map[c.idx] = 1'b1;
          if (!total_known) begin
            prim_total  = c.pcount;
            total_known = 1'b1;
          end
          if (is_prim) begin
            if (prim_avail < CNT_MAX) prim_avail++;
          end else begin
            if (sec_avail < CNT_MAX) sec_avail++;
            if (!size_known) begin
              sec_size   = c.len;
              size_known = 1'b1;
            end
          end
        end
      end
      ACT_PULL: begin
        // walk from the forwarded point; gaps skip or stop
        for (i = fwd_count; i < prim_avail && i < MAX_FRAG; i++) begin
          if (!avail_map[i]) begin
            if (c.skip) continue;
            break;
          end
          released.insert(released.size(), i[5:0]);
          if (released.size() >= RESULT_LIMIT) break;
        end
        fwd_count = fwd_count + 7'(released.size());
      end
      ACT_NEW: clear_block_state();
      default: ;
    endcase
    if (typed) e = terr;

    // status after the whole command
    have        = {1'b0, prim_avail} + {1'b0, sec_avail};
    r.known     = total_known;
    r.all_avail = total_known && (prim_avail == prim_total);
    r.can_rec   = total_known && (have >= {1'b0, prim_total});
    r.all_fwd   = total_known && (fwd_count == prim_total);
    r.missing   = total_known ? ({1'b0, prim_total} - have) : 8'sd0;
    r.fwd       = fwd_count;
    r.err       = e;
    if (released.size() == 0) begin
      r.index = '0;
      r.valid = 1'b0;
      r.last  = 1'b1;
      queue_expected(r);
    end else begin
      foreach (released[k]) begin
        r.index = released[k];
        r.valid = 1'b1;
        r.last  = (k == released.size() - 1);
        queue_expected(r);
      end
    end
  endtask

  // Drive one transaction, idling first at the phase's rate; enters and leaves at negedge
  task automatic send_cmd(input frag_cmd_t c, input bit typed, input err_e terr);
    bit taken;
    idle_pct = idle_phase_pct[(cmds_sent / 45) % 4];
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start             = 1'b1;
    action_i          = c.act;
    fragment_index_i  = c.idx;
    primary_count_i   = c.pcount;
    payload_len_i     = c.len;
    discard_missing_i = c.skip;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1'b1;
        apply_tracker_cmd(c, typed, terr);
        cmds_sent++;
      end
      @(negedge clk_i);
    end
  endtask

  function automatic frag_cmd_t rand_cmd(input action_e a);
    frag_cmd_t c;
    c.act    = a;
    c.idx    = 6'($urandom);
    c.pcount = 7'($urandom);
    c.len    = 12'($urandom);
    c.skip   = 1'($urandom);
    return c;
  endfunction

  function automatic dir_row_t mk_row(input action_e a, input int unsigned idx,
                                      input int unsigned pc, input int unsigned len,
                                      input bit skip, input bit typed, input err_e terr);
    dir_row_t r;
    r.cmd.act    = a;
    r.cmd.idx    = 6'(idx);
    r.cmd.pcount = 7'(pc);
    r.cmd.len    = 12'(len);
    r.cmd.skip   = skip;
    r.typed      = typed;
    r.terr       = terr;
    return r;
  endfunction

  task automatic send_pull();
    send_cmd(rand_cmd(ACT_PULL), 1'b0, ERR_OK);
  endtask

  // One block: new block, then mostly well-formed adds in random order with pulls mixed in
  task automatic run_random_block();
    int unsigned order [$];
    int unsigned sent_idx [$];
    int unsigned pc, nsec, gap_pct, roll, j, k, tmp;
    logic [11:0] slen;
    frag_cmd_t   c;
    send_cmd(rand_cmd(ACT_NEW), 1'b0, ERR_OK);
    roll = $urandom_range(99);
    if (roll < 5) pc = MAX_FRAG;
    else if (roll < 15) pc = $urandom_range(MAX_FRAG, 9);
    else pc = $urandom_range(8, 1);
    tmp     = (MAX_FRAG - pc < 4) ? MAX_FRAG - pc : 4;
    nsec    = $urandom_range(tmp, 0);
    slen    = 12'($urandom);
    gap_pct = $urandom_range(1) ? 0 : 15;
    for (j = 0; j < pc + nsec; j++)
      if ($urandom_range(99) >= gap_pct) order.insert(order.size(), j);
    for (k = order.size(); k > 1; k--) begin
      j            = $urandom_range(k - 1);
      tmp          = order[k-1];
      order[k-1]   = order[j];
      order[j]     = tmp;
    end

    foreach (order[n]) begin
      if ($urandom_range(99) < 20) send_pull();
      roll = $urandom_range(99);
      c    = rand_cmd(ACT_ADD);
      // noise transactions ahead of the regular add
      if (roll < 6 && sent_idx.size() > 0) begin
        c.idx    = 6'(sent_idx[$urandom_range(sent_idx.size() - 1)]);
        c.pcount = 7'(pc);
        c.len    = (c.idx >= pc) ? slen : c.len;
        send_cmd(c, 1'b0, ERR_OK);
      end else if (roll < 11) begin
        c.idx = 6'(order[n]);
        send_cmd(c, 1'b0, ERR_OK);
      end else if (roll < 15) begin
        c.idx    = 6'(order[n]);
        c.pcount = 7'(pc);
        send_cmd(c, 1'b0, ERR_OK);
      end else if (roll < 18) begin
        send_cmd(c, 1'b0, ERR_OK);
      end else if (roll < 20) begin
        send_cmd(rand_cmd(ACT_NOP), 1'b0, ERR_OK);
      end
      c        = rand_cmd(ACT_ADD);
      c.idx    = 6'(order[n]);
      c.pcount = 7'(pc);
      if (order[n] >= pc) c.len = slen;
      send_cmd(c, 1'b0, ERR_OK);
      sent_idx.insert(sent_idx.size(), order[n]);
    end
    send_pull();
    if ($urandom_range(1)) begin
      c      = rand_cmd(ACT_PULL);
      c.skip = 1'b1;
      send_cmd(c, 1'b0, ERR_OK);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    frag_result_t got;
    frag_result_t want;
    if (rst_ni && done_o) begin
      got = {out_index_o, index_valid_o, last_result_o, error_code_o, count_known_o,
             all_available_o, can_recover_o, all_forwarded_o, missing_primary_o,
             forwarded_count_o};
      if (tracker_results_q.size() == 0) begin
        flag_mismatch({"unexpected result ", fmt_result(got)});
      end else begin
        want = tracker_results_q.pop_front();
        if (got !== want)
          flag_mismatch({"got ", fmt_result(got), " exp ", fmt_result(want)});
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst_ni            = 1'b0;
    start             = 1'b0;
    action_i          = ACT_NOP;
    fragment_index_i  = '0;
    primary_count_i   = '0;
    payload_len_i     = '0;
    discard_missing_i = 1'b0;
    cmds_sent         = 0;
    mismatches        = 0;
    cycle_cnt         = 0;
    idle_pct          = 0;
    clear_block_state();

    // directed table
    add_row(mk_row(ACT_NOP,  0,   0,    0, 0, 1, ERR_OK));
    add_row(mk_row(ACT_PULL, 0,   0,    0, 1, 1, ERR_OK));
    add_row(mk_row(ACT_ADD,  0,   0,    0, 0, 1, ERR_RANGE));
    add_row(mk_row(ACT_ADD,  5,  65,   10, 0, 1, ERR_RANGE));
    add_row(mk_row(ACT_ADD, 63, 127, 4095, 1, 1, ERR_RANGE));
    add_row(mk_row(ACT_ADD,  0,   4,    0, 0, 1, ERR_OK));
    add_row(mk_row(ACT_ADD,  0,   4,    0, 0, 1, ERR_DUP));
    add_row(mk_row(ACT_ADD,  1,   5,    0, 0, 1, ERR_COUNT));
    add_row(mk_row(ACT_ADD,  2,   4,  200, 0, 1, ERR_OK));
    add_row(mk_row(ACT_ADD,  4,   4, 4095, 0, 1, ERR_OK));
    add_row(mk_row(ACT_ADD,  5,   4,  100, 0, 1, ERR_SIZE));
    add_row(mk_row(ACT_ADD,  6,   4, 4095, 0, 1, ERR_OK));
    // stop at the gap, then skip it with nothing left to release
    add_row(mk_row(ACT_PULL, 0,   0,    0, 0, 0, ERR_OK));
    add_row(mk_row(ACT_PULL, 0,   0,    0, 1, 0, ERR_OK));
    add_row(mk_row(ACT_ADD,  1,   4,   17, 0, 1, ERR_OK));
    add_row(mk_row(ACT_ADD,  3,   4,   17, 0, 1, ERR_OK));
    add_row(mk_row(ACT_PULL, 0,   0,    0, 0, 0, ERR_OK));
    add_row(mk_row(ACT_NEW, 63, 127, 4095, 1, 1, ERR_OK));
    add_row(mk_row(ACT_ADD, 63,  64, 4095, 1, 1, ERR_OK));
    add_row(mk_row(ACT_ADD,  0,  64,    0, 0, 1, ERR_OK));
    // skip mode: the walk ends at the primary-available count, so only index 0 goes; the next pull releases nothing
    add_row(mk_row(ACT_PULL, 0,   0,    0, 1, 0, ERR_OK));
    add_row(mk_row(ACT_PULL, 0,   0,    0, 1, 0, ERR_OK));
    add_row(mk_row(ACT_NOP, 63, 127, 4095, 1, 1, ERR_OK));
    add_row(mk_row(ACT_NEW,  0,   0,    0, 0, 1, ERR_OK));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].terr);
    while (cmds_sent < dir_rows.size() + RANDOM_CMDS) run_random_block();
    start = 1'b0;

    // drain, then let the block settle
    while (tracker_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/fbft_pkg.sv
rtl/fbft_map.sv
rtl/fec_block_fragment_tracker.sv
tb/tb_top.sv
